FILE: rtl/orf_pkg.sv
// orf_pkg: shared types and constants for the overlap redundancy filter
// used by orf_ctrl, orf_dp and overlap_redundancy_filter; no dependencies
package orf_pkg;

	localparam int MAX_RECORDS = 1024;
	localparam int IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int ID_W = 32;
	localparam int LEN_W = 16;
	localparam int SCORE_W = 8;
	localparam int KIND_W = 3;

	localparam logic [1:0] MARK_NONE = 2'b00;
	localparam logic [1:0] MARK_FWD = 2'b01;
	localparam logic [1:0] MARK_BOTH = 2'b11;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    first_read;
		logic [ID_W-1:0]    second_read;
		logic [KIND_W-1:0]  overlap_kind;
		logic [LEN_W-1:0]   first_length;
		logic [LEN_W-1:0]   second_length;
		logic [SCORE_W-1:0] error_score;
	} req_t;

	typedef struct packed {
		logic               valid_res;
		logic               is_last;
		logic [ID_W-1:0]    out_first_read;
		logic [ID_W-1:0]    out_second_read;
		logic [KIND_W-1:0]  out_kind;
		logic [LEN_W-1:0]   out_first_length;
		logic [LEN_W-1:0]   out_second_length;
		logic [SCORE_W-1:0] out_score;
		logic               overflowed;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]    first_read;
		logic [ID_W-1:0]    second_read;
		logic [KIND_W-1:0]  kind;
		logic [LEN_W-1:0]   first_len;
		logic [LEN_W-1:0]   second_len;
		logic [SCORE_W-1:0] score;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD_RD,
		ST_FWD_EV,
		ST_BWD_RD,
		ST_BWD_EV,
		ST_SCAN_RD,
		ST_SCAN_EV
	} state_t;

	typedef enum logic [1:0] {
		AM_FWD,
		AM_BWD,
		AM_SCAN
	} addr_mode_t;

	typedef struct packed {
		logic       load;
		logic       fwd_init;
		logic       fwd_eval;
		logic       bwd_init;
		logic       bwd_eval;
		logic       scan_init;
		logic       scan_next;
		logic       emit;
		addr_mode_t addr_mode;
	} cmd_t;

	typedef struct packed {
		logic phase_fetch;
		logic idx_end;
		logic idx_zero;
		logic ptr_end;
		logic found;
	} sts_t;

endpackage

FILE: rtl/orf_ctrl.sv
// orf_ctrl: sequencer for loads, the two filter passes and the fetch scan
// depends on orf_pkg; drives commands into orf_dp
module orf_ctrl import orf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_action,
	input  logic slot_free,
	input  sts_t sts,
	output logic req_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.addr_mode = AM_SCAN;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_action == ACT_LOAD) begin
						cmd.load = 1'b1;
					end else if (sts.phase_fetch) begin
						state_d = ST_SCAN_RD;
					end else begin
						cmd.fwd_init = 1'b1;
						state_d = ST_FWD_RD;
					end
				end
			end
			ST_FWD_RD: begin
				cmd.addr_mode = AM_FWD;
				if (sts.idx_end) begin
					cmd.bwd_init = 1'b1;
					state_d = ST_BWD_RD;
				end else begin
					state_d = ST_FWD_EV;
				end
			end
			ST_FWD_EV: begin
				cmd.addr_mode = AM_FWD;
				cmd.fwd_eval = 1'b1;
				state_d = ST_FWD_RD;
			end
			ST_BWD_RD: begin
				cmd.addr_mode = AM_BWD;
				if (sts.idx_zero) begin
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_BWD_EV;
				end
			end
			ST_BWD_EV: begin
				cmd.addr_mode = AM_BWD;
				cmd.bwd_eval = 1'b1;
				state_d = ST_BWD_RD;
			end
			ST_SCAN_RD: begin
				if (sts.ptr_end) begin
					if (slot_free) begin
						cmd.emit = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				if (sts.found) begin
					if (slot_free) begin
						cmd.emit = 1'b1;
						cmd.scan_next = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/orf_dp.sv
// orf_dp: record and mark memories, counters, last-kept record and compare
// depends on orf_pkg; controlled by orf_ctrl
module orf_dp import orf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t res
);

	rec_t rec_mem [MAX_RECORDS];
	logic [1:0] mark_mem [MAX_RECORDS];

	rec_t rd_rec_q;
	logic [1:0] rd_mark_q;
	rec_t prev_q;
	logic prev_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx_q;
	logic last_valid_q;
	logic phase_fetch_q;
	logic overflow_q;

	logic [IDX_W-1:0] addr;
	logic [CNT_W-1:0] eff_cnt;
	logic self_ovl;
	logic full;
	logic rec_we;
	rec_t wr_rec;
	logic mark_we;
	logic [1:0] mark_wd;
	logic keep;
	logic bwd_keep;
	logic [LEN_W:0] dlen;
	logic [LEN_W:0] absd;
	logic [SCORE_W+1:0] rhs;
	logic [LEN_W+2:0] lhs_ext;
	logic [LEN_W+2:0] rhs_ext;

	always_comb begin
		case (cmd.addr_mode)
			AM_FWD:  addr = idx_q[IDX_W-1:0];
			AM_BWD:  addr = IDX_W'(idx_q - 1'b1);
			AM_SCAN: addr = ptr_q[IDX_W-1:0];
			default: addr = ptr_q[IDX_W-1:0];
		endcase
	end

	// load path
	assign eff_cnt = phase_fetch_q ? '0 : count_q;
	assign self_ovl = (req.first_read == req.second_read);
	assign full = (eff_cnt >= CNT_W'(MAX_RECORDS));
	assign rec_we = cmd.load && !self_ovl && !full;
	assign wr_rec = '{
		first_read: req.first_read,
		second_read: req.second_read,
		kind: req.overlap_kind,
		first_len: req.first_length,
		second_len: req.second_length,
		score: req.error_score
	};

	// redundancy compare against last kept record
	assign dlen = {1'b0, rd_rec_q.first_len} - {1'b0, prev_q.first_len};
	assign absd = dlen[LEN_W] ? (~dlen + 1'b1) : dlen;
	assign rhs = {2'b00, prev_q.score} - {2'b00, rd_rec_q.score} + 1'b1;
	assign lhs_ext = {2'b00, absd};
	assign rhs_ext = {{(LEN_W + 1 - SCORE_W){rhs[SCORE_W+1]}}, rhs};
	assign keep = !prev_valid_q
		|| (rd_rec_q.first_read != prev_q.first_read)
		|| (rd_rec_q.second_read != prev_q.second_read)
		|| (rd_rec_q.kind != prev_q.kind)
		|| ($signed(lhs_ext) > $signed(rhs_ext));
	assign bwd_keep = rd_mark_q[0] && keep;

	always_comb begin
		mark_we = 1'b0;
		mark_wd = MARK_NONE;
		if (cmd.fwd_eval) begin
			mark_we = 1'b1;
			mark_wd = keep ? MARK_FWD : MARK_NONE;
		end else if (cmd.bwd_eval && bwd_keep) begin
			mark_we = 1'b1;
			mark_wd = MARK_BOTH;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[eff_cnt[IDX_W-1:0]] <= wr_rec;
		end
		rd_rec_q <= rec_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[addr] <= mark_wd;
		end
		rd_mark_q <= mark_mem[addr];
	end

	always_ff @(posedge clk) begin
		if ((cmd.fwd_eval && keep) || (cmd.bwd_eval && bwd_keep)) begin
			prev_q <= rd_rec_q;
		end
		if (cmd.bwd_eval && bwd_keep && !last_valid_q) begin
			last_idx_q <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
			idx_q <= '0;
			prev_valid_q <= 1'b0;
			last_valid_q <= 1'b0;
			phase_fetch_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				phase_fetch_q <= 1'b0;
				ptr_q <= '0;
				overflow_q <= (phase_fetch_q ? 1'b0 : overflow_q) || (!self_ovl && full);
				count_q <= rec_we ? CNT_W'(eff_cnt + 1'b1) : eff_cnt;
			end
			if (cmd.fwd_init) begin
				idx_q <= '0;
				prev_valid_q <= 1'b0;
			end
			if (cmd.fwd_eval) begin
				idx_q <= idx_q + 1'b1;
				if (keep) begin
					prev_valid_q <= 1'b1;
				end
			end
			if (cmd.bwd_init) begin
				idx_q <= count_q;
				prev_valid_q <= 1'b0;
				last_valid_q <= 1'b0;
			end
			if (cmd.bwd_eval) begin
				idx_q <= idx_q - 1'b1;
				if (bwd_keep) begin
					prev_valid_q <= 1'b1;
					last_valid_q <= 1'b1;
				end
			end
			if (cmd.scan_init) begin
				ptr_q <= '0;
				phase_fetch_q <= 1'b1;
			end
			if (cmd.scan_next) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign sts.phase_fetch = phase_fetch_q;
	assign sts.idx_end = (idx_q == count_q);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.ptr_end = (ptr_q >= count_q);
	assign sts.found = (rd_mark_q == MARK_BOTH);

	always_comb begin
		res = '0;
		res.overflowed = overflow_q;
		if (!sts.ptr_end) begin
			res.valid_res = 1'b1;
			res.is_last = last_valid_q && (ptr_q[IDX_W-1:0] == last_idx_q);
			res.out_first_read = rd_rec_q.first_read;
			res.out_second_read = rd_rec_q.second_read;
			res.out_kind = rd_rec_q.kind;
			res.out_first_length = rd_rec_q.first_len;
			res.out_second_length = rd_rec_q.second_len;
			res.out_score = rd_rec_q.score;
		end
	end

endmodule

FILE: rtl/overlap_redundancy_filter.sv
// overlap_redundancy_filter: top level with the result register
// depends on orf_pkg, orf_ctrl and orf_dp
//
// A load transaction stores one overlap record; records whose two read ids
// match are dropped, and loads past MAX_RECORDS are dropped and flagged. The
// first fetch of a set runs a forward and a backward filter pass over the
// record memory, in which every record is read through the single registered
// read port and then evaluated. Each fetch then scans forward, reading and then
// evaluating each record visited, until the next survivor or until the set is
// exhausted. Results sit in an output register, so loads are taken while a
// result waits. No clearing pass follows reset.
module overlap_redundancy_filter import orf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;
	rsp_t res;
	logic slot_free;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	orf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.slot_free  (slot_free),
		.sts        (sts),
		.req_stall  (req_stall),
		.cmd        (cmd)
	);

	orf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for overlap_redundancy_filter, load and fetch transactions
// with random gaps and stalls; survivors predicted by a scoreboard class
// depends on orf_pkg and the overlap_redundancy_filter rtl

class survivor_board;
	orf_pkg::rec_t recs[orf_pkg::MAX_RECORDS];
	logic [1:0] marks[orf_pkg::MAX_RECORDS];
	int rec_count;
	int scan_ptr;
	int last_idx;
	bit fetching;
	bit ovf;
	int errors;
	orf_pkg::rsp_t pending_survivors[$];

	function new();
		rec_count = 0;
		scan_ptr = 0;
		last_idx = -1;
		fetching = 0;
		ovf = 0;
		errors = 0;
	endfunction

	// record c survives against kept record p unless same pair and kind with a small length change
	function bit kept_after(int p, int c);
		int dlen;
		int slack;
		if (recs[p].first_read != recs[c].first_read ||
				recs[p].second_read != recs[c].second_read ||
				recs[p].kind != recs[c].kind)
			return 1'b1;
		dlen = int'(recs[c].first_len) - int'(recs[p].first_len);
		if (dlen < 0)
			dlen = -dlen;
		slack = int'(recs[p].score) - int'(recs[c].score) + 1;
		return dlen > slack;
	endfunction

	function void run_filter();
		int i;
		int prev;
		prev = -1;
		for (i = 0; i < rec_count; i++) begin
			marks[i] = orf_pkg::MARK_NONE;
			if (prev < 0 || kept_after(prev, i)) begin
				marks[i] = orf_pkg::MARK_FWD;
				prev = i;
			end
		end
		prev = -1;
		last_idx = -1;
		for (i = rec_count - 1; i >= 0; i--) begin
			if (marks[i] == orf_pkg::MARK_FWD && (prev < 0 || kept_after(prev, i))) begin
				marks[i] = orf_pkg::MARK_BOTH;
				prev = i;
				if (last_idx < 0)
					last_idx = i;
			end
		end
	endfunction

	function void take_request(orf_pkg::req_t r);
		orf_pkg::rsp_t want;
		int i;
		if (r.action == orf_pkg::ACT_LOAD) begin
			if (fetching) begin
				fetching = 0;
				rec_count = 0;
				scan_ptr = 0;
				ovf = 0;
			end
			if (r.first_read == r.second_read)
				return;
			if (rec_count >= orf_pkg::MAX_RECORDS) begin
				ovf = 1;
				return;
			end
			recs[rec_count].first_read = r.first_read;
			recs[rec_count].second_read = r.second_read;
			recs[rec_count].kind = r.overlap_kind;
			recs[rec_count].first_len = r.first_length;
			recs[rec_count].second_len = r.second_length;
			recs[rec_count].score = r.error_score;
			rec_count++;
			return;
		end
		if (!fetching) begin
			run_filter();
			scan_ptr = 0;
			fetching = 1;
		end
		want = '0;
		want.overflowed = ovf;
		i = scan_ptr;
		while (i < rec_count && marks[i] != orf_pkg::MARK_BOTH)
			i++;
		if (i >= rec_count) begin
			scan_ptr = rec_count;
		end else begin
			scan_ptr = i + 1;
			want.valid_res = 1'b1;
			want.is_last = (i == last_idx);
			want.out_first_read = recs[i].first_read;
			want.out_second_read = recs[i].second_read;
			want.out_kind = recs[i].kind;
			want.out_first_length = recs[i].first_len;
			want.out_second_length = recs[i].second_len;
			want.out_score = recs[i].score;
		end
		pending_survivors = {pending_survivors, want};
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 100)
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
	endtask

	task check_result(orf_pkg::rsp_t got);
		orf_pkg::rsp_t want;
		if (pending_survivors.size() == 0) begin
			report("result with none pending", 64'(got.valid_res), 64'd0);
			return;
		end
		want = pending_survivors.pop_front();
		if (got.valid_res !== want.valid_res)
			report("valid_res", 64'(got.valid_res), 64'(want.valid_res));
		if (got.is_last !== want.is_last)
			report("is_last", 64'(got.is_last), 64'(want.is_last));
		if (got.out_first_read !== want.out_first_read)
			report("out_first_read", 64'(got.out_first_read), 64'(want.out_first_read));
		if (got.out_second_read !== want.out_second_read)
			report("out_second_read", 64'(got.out_second_read),
				64'(want.out_second_read));
		if (got.out_kind !== want.out_kind)
			report("out_kind", 64'(got.out_kind), 64'(want.out_kind));
		if (got.out_first_length !== want.out_first_length)
			report("out_first_length", 64'(got.out_first_length),
				64'(want.out_first_length));
		if (got.out_second_length !== want.out_second_length)
			report("out_second_length", 64'(got.out_second_length),
				64'(want.out_second_length));
		if (got.out_score !== want.out_score)
			report("out_score", 64'(got.out_score), 64'(want.out_score));
		if (got.overflowed !== want.overflowed)
			report("overflowed", 64'(got.overflowed), 64'(want.overflowed));
	endtask
endclass

module tb;
	import orf_pkg::*;

	localparam int ITEM_GOAL = 1450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	survivor_board sb;
	int sent = 0;
	bit calm = 1'b0;
	int stall_left = 0;
	int stall_len;
	logic [ID_W-1:0] pool_a[3];
	logic [ID_W-1:0] pool_b[3];
	logic [LEN_W-1:0] base_len;
	logic [KIND_W-1:0] pool_kind;

	overlap_redundancy_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else if (calm || rsp_stall) begin
			rsp_stall <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			stall_len = pick_gap();
			rsp_stall <= (stall_len != 0);
			stall_left = (stall_len > 0) ? stall_len - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
		if (arst_n && req_valid && !req_stall)
			sb.take_request(req);
	end

	task automatic send_item(req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (item.action == ACT_FETCH || item.first_read != item.second_read)
			sent++;
	endtask

	task automatic load_rec(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic [KIND_W-1:0] k,
			logic [LEN_W-1:0] l1, logic [LEN_W-1:0] l2, logic [SCORE_W-1:0] s);
		req_t item;
		item.action = ACT_LOAD;
		item.first_read = a;
		item.second_read = b;
		item.overlap_kind = k;
		item.first_length = l1;
		item.second_length = l2;
		item.error_score = s;
		send_item(item);
	endtask

	task automatic fetch_next();
		req_t item;
		item.action = ACT_FETCH;
		item.first_read = $urandom;
		item.second_read = $urandom;
		item.overlap_kind = KIND_W'($urandom_range(0, 7));
		item.first_length = LEN_W'($urandom_range(0, 65535));
		item.second_length = LEN_W'($urandom_range(0, 65535));
		item.error_score = SCORE_W'($urandom_range(0, 255));
		send_item(item);
	endtask

	task automatic new_pool();
		int i;
		for (i = 0; i < 3; i++) begin
			pool_a[i] = $urandom;
			pool_b[i] = $urandom;
		end
		base_len = LEN_W'($urandom_range(0, 65535));
		pool_kind = KIND_W'($urandom_range(0, 7));
	endtask

	// mostly near-duplicates of a few read pairs, some fully random records
	task automatic load_pooled(bit allow_self);
		int p;
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		logic [KIND_W-1:0] k;
		logic [LEN_W-1:0] l1;
		logic [SCORE_W-1:0] s;
		p = $urandom_range(0, 2);
		a = pool_a[p];
		b = pool_b[p];
		k = ($urandom_range(0, 3) == 0) ? KIND_W'($urandom_range(0, 7)) : pool_kind;
		l1 = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 65535))
				: LEN_W'(base_len + $urandom_range(0, 6));
		s = ($urandom_range(0, 4) == 0) ? SCORE_W'($urandom_range(0, 255))
				: SCORE_W'($urandom_range(0, 8));
		if ($urandom_range(0, 9) == 0) begin
			a = $urandom;
			b = $urandom;
		end
		if (allow_self && $urandom_range(0, 19) == 0)
			b = a;
		else if (a == b)
			b = ~a;
		load_rec(a, b, k, l1, LEN_W'($urandom_range(0, 65535)), s);
	endtask

	initial begin
		int n;
		int nf;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fetch_next();
		load_rec(32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 16'h0000, 16'hFFFF, 8'hFF);
		load_rec(32'h1234_5678, 32'h1234_5678, 3'd2, 16'h0001, 16'h0001, 8'h01);
		load_rec(32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 16'h0001, 16'h0000, 8'h00);
		load_rec(32'h0000_0000, 32'hFFFF_FFFF, 3'd7, 16'h0005, 16'h0005, 8'h05);
		load_rec(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 16'hFFFF, 16'h0000, 8'h00);
		load_rec(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 16'h0000, 16'hAAAA, 8'hFF);
		load_rec(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 16'h0002, 16'h5555, 8'hFF);
		load_rec(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 16'h0003, 16'h1234, 8'hFF);
		repeat (7) fetch_next();
		// backward pass drops a record that the forward pass kept
		load_rec(32'hA5A5_A5A5, 32'h5A5A_5A5A, 3'd3, 16'd0, 16'd9, 8'd0);
		load_rec(32'hA5A5_A5A5, 32'h5A5A_5A5A, 3'd3, 16'd5, 16'd9, 8'd10);
		repeat (3) fetch_next();

		// fill the store, then overflow it
		new_pool();
		repeat (MAX_RECORDS) load_pooled(1'b0);
		load_rec(32'h0BAD_F00D, 32'h0BAD_F00D, 3'd1, 16'd1, 16'd1, 8'd1);
		repeat (2) load_pooled(1'b0);
		repeat (8) fetch_next();

		while (sent < ITEM_GOAL) begin
			calm = ($urandom_range(0, 4) == 0);
			new_pool();
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			repeat (n) load_pooled(1'b1);
			nf = $urandom_range(0, n + 2);
			repeat (nf) fetch_next();
		end
		calm = 1'b0;

		req_valid <= 1'b0;
		while (sb.pending_survivors.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule

FILE: overlap_redundancy_filter.f
rtl/orf_pkg.sv
rtl/orf_ctrl.sv
rtl/orf_dp.sv
rtl/overlap_redundancy_filter.sv
bench/tb.sv
